/* rtl/fixed_point_alu_macros.svh */
// Assertion macros for the fixed-point ALU.
// Needs clk and rst_n in the scope that uses them.
`ifndef FIXED_POINT_ALU_MACROS_SVH
`define FIXED_POINT_ALU_MACROS_SVH
`ifndef SYNTH
`define FPA_ASSERT_NOW(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define FPA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define FPA_ASSERT_NOW(lbl, expr, msg)
`define FPA_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

/* rtl/fpa_pkg.sv */
// Types shared by the fixed-point ALU and its users.
// No dependencies.
package fpa_pkg;

    typedef enum logic [3:0] {
        CMD_ADD      = 4'd0,
        CMD_SUB      = 4'd1,
        CMD_MUL      = 4'd2,
        CMD_DIV      = 4'd3,
        CMD_MIN      = 4'd4,
        CMD_MAX      = 4'd5,
        CMD_INC      = 4'd6,
        CMD_DEC      = 4'd7,
        CMD_TO_INT   = 4'd8,
        CMD_FROM_INT = 4'd9
    } cmd_t;

    typedef struct packed {
        logic [3:0]         cmd;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } in_t;

    typedef struct packed {
        logic signed [31:0] result;
        logic               a_greater;
        logic               a_less;
        logic               a_equal;
        logic               overflow;
        logic               divide_by_zero;
    } out_t;

    localparam logic [31:0] RAW_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] RAW_MIN = 32'h8000_0000;

endpackage

/* rtl/fixed_point_alu.sv */
// Fixed-point ALU, pipelined, with a one-bit-per-stage divider.
// Depends on fpa_pkg and fixed_point_alu_macros.svh.
//
//  port        dir  handshake           payload
//  req         in   start && !busy      fpa_pkg::in_t
//  rsp         out  done, one cycle     fpa_pkg::out_t
//
// One word enters per cycle; busy stays low. The pipeline depth is set by the
// restoring divider, which resolves one quotient bit per stage
// (FRAC_BITS + 34 stages). All operations ride the same pipeline, so results
// leave in order. Reset clears the valid bits only. The receiver cannot stall.
`include "fixed_point_alu_macros.svh"

module fixed_point_alu #(
    parameter int FRAC_BITS = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  fpa_pkg::in_t  req,
    output logic          done,
    output fpa_pkg::out_t rsp
);

    localparam int QW   = FRAC_BITS + 34;   // quotient and numerator width
    localparam int RW   = 34;               // partial remainder width
    localparam int LAST = QW + 1;           // index of last pipe stage
    localparam logic [63:0] HALF = (64'd1 << FRAC_BITS) >> 1;

    typedef struct packed {
        fpa_pkg::cmd_t      cmd;
        logic               gt;
        logic               lt;
        logic               eq;
        logic               a_neg;
        logic               a_zero;
        logic               dz;
        logic               qneg;
        logic [31:0]        res;
        logic               ovf;
        logic signed [63:0] prod;
        logic [QW-1:0]      num;
        logic [RW-1:0]      rem;
        logic [32:0]        den;
        logic [QW-1:0]      quo;
    } stage_t;

    // {overflow, value} of a 64-bit signed value clipped to 32 bits
    function automatic logic [32:0] sat64(input logic signed [63:0] v);
        logic in_range;
        begin
            in_range = (&v[63:31]) || (~|v[63:31]);
            if (in_range)
                sat64 = {1'b0, v[31:0]};
            else if (v[63])
                sat64 = {1'b1, fpa_pkg::RAW_MIN};
            else
                sat64 = {1'b1, fpa_pkg::RAW_MAX};
        end
    endfunction

    fpa_pkg::in_t in_reg;
    logic         in_vld_reg;
    stage_t       pipe_reg [1:LAST];
    logic         vld_reg  [1:LAST];
    fpa_pkg::out_t out_reg;
    logic         out_vld_reg;

    assign busy = 1'b0;
    assign done = out_vld_reg;
    assign rsp  = out_reg;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else
            in_vld_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        in_reg <= req;
    end

    // setup stage: compares, simple ops, product, divider operands
    stage_t s1_next;
    logic signed [63:0] a64;
    logic signed [63:0] b64;
    logic [32:0]        a_mag;
    logic [32:0]        b_mag;
    logic [32:0]        sat_w;

    always_comb
    begin
        a64   = 64'(in_reg.operand_a);
        b64   = 64'(in_reg.operand_b);
        a_mag = in_reg.operand_a[31] ? (33'd0 - {1'b1, in_reg.operand_a})
                                     : {1'b0, in_reg.operand_a};
        b_mag = in_reg.operand_b[31] ? (33'd0 - {1'b1, in_reg.operand_b})
                                     : {1'b0, in_reg.operand_b};
        sat_w = '0;
        s1_next        = '0;
        s1_next.cmd    = fpa_pkg::cmd_t'(in_reg.cmd);
        s1_next.gt     = in_reg.operand_a > in_reg.operand_b;
        s1_next.lt     = in_reg.operand_a < in_reg.operand_b;
        s1_next.eq     = in_reg.operand_a == in_reg.operand_b;
        s1_next.a_neg  = in_reg.operand_a[31];
        s1_next.a_zero = in_reg.operand_a == 32'sd0;
        s1_next.dz     = in_reg.operand_b == 32'sd0;
        s1_next.qneg   = in_reg.operand_a[31] ^ in_reg.operand_b[31];
        s1_next.prod   = in_reg.operand_a * in_reg.operand_b;
        s1_next.num    = (QW'(a_mag) << (FRAC_BITS + 1)) + QW'(b_mag);
        s1_next.den    = {b_mag[31:0], 1'b0};
        s1_next.rem    = '0;
        s1_next.quo    = '0;
        unique case (in_reg.cmd)
            fpa_pkg::CMD_ADD:      sat_w = sat64(a64 + b64);
            fpa_pkg::CMD_SUB:      sat_w = sat64(a64 - b64);
            fpa_pkg::CMD_MIN:      sat_w = {1'b0, s1_next.lt ? in_reg.operand_a
                                                             : in_reg.operand_b};
            fpa_pkg::CMD_MAX:      sat_w = {1'b0, s1_next.gt ? in_reg.operand_a
                                                             : in_reg.operand_b};
            fpa_pkg::CMD_INC:      sat_w = sat64(a64 + 64'sd1);
            fpa_pkg::CMD_DEC:      sat_w = sat64(a64 - 64'sd1);
            fpa_pkg::CMD_TO_INT:   sat_w = {1'b0, 32'(in_reg.operand_a >>> FRAC_BITS)};
            fpa_pkg::CMD_FROM_INT: sat_w = sat64(a64 <<< FRAC_BITS);
            default:               sat_w = '0;
        endcase
        s1_next.ovf = sat_w[32];
        s1_next.res = sat_w[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[1] <= 1'b0;
        else
            vld_reg[1] <= in_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        pipe_reg[1] <= s1_next;
    end

    // divider stages; the first two also round and clip the product
    for (genvar i = 2; i <= LAST; i++)
    begin : g_stage
        stage_t          st_next;
        logic [RW-1:0]   trial;
        logic            fits;
        logic [63:0]     pmag;
        logic [32:0]     msat;

        always_comb
        begin
            st_next = pipe_reg[i-1];
            trial   = {pipe_reg[i-1].rem[RW-2:0], pipe_reg[i-1].num[QW+1-i]};
            fits    = trial >= {1'b0, pipe_reg[i-1].den};
            st_next.rem = fits ? (trial - {1'b0, pipe_reg[i-1].den}) : trial;
            st_next.quo = {pipe_reg[i-1].quo[QW-2:0], fits};
            pmag = '0;
            msat = '0;
            if (i == 2)
            begin
                // keep the rounded magnitude in prod; the product sign stays in qneg
                pmag = pipe_reg[i-1].prod[63] ? (64'd0 - pipe_reg[i-1].prod)
                                              : pipe_reg[i-1].prod;
                st_next.prod = $signed((pmag + HALF) >> FRAC_BITS);
                st_next.num[QW-1] = pipe_reg[i-1].num[QW-1];
            end
            if (i == 3 && pipe_reg[i-1].cmd == fpa_pkg::CMD_MUL)
            begin
                if (pipe_reg[i-1].a_neg ^ pipe_reg[i-1].qneg ^ pipe_reg[i-1].a_neg)
                    msat = sat64(64'sd0 - pipe_reg[i-1].prod);
                else
                    msat = sat64(pipe_reg[i-1].prod);
                st_next.ovf = msat[32];
                st_next.res = msat[31:0];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i] <= 1'b0;
            else
                vld_reg[i] <= vld_reg[i-1];
        end

        always_ff @(posedge clk)
        begin
            pipe_reg[i] <= st_next;
        end
    end

    // finish the divide and select the word
    fpa_pkg::out_t out_next;
    logic [QW-1:0] q;

    always_comb
    begin
        q = pipe_reg[LAST].quo;
        out_next.a_greater      = pipe_reg[LAST].gt;
        out_next.a_less         = pipe_reg[LAST].lt;
        out_next.a_equal        = pipe_reg[LAST].eq;
        out_next.result         = pipe_reg[LAST].res;
        out_next.overflow       = pipe_reg[LAST].ovf;
        out_next.divide_by_zero = 1'b0;
        if (pipe_reg[LAST].cmd == fpa_pkg::CMD_DIV)
        begin
            if (pipe_reg[LAST].dz)
            begin
                out_next.divide_by_zero = 1'b1;
                out_next.overflow       = 1'b0;
                if (pipe_reg[LAST].a_zero)
                    out_next.result = '0;
                else if (pipe_reg[LAST].a_neg)
                    out_next.result = fpa_pkg::RAW_MIN;
                else
                    out_next.result = fpa_pkg::RAW_MAX;
            end
            else if (pipe_reg[LAST].qneg)
            begin
                out_next.overflow = (|q[QW-1:32]) || (q[31] && (|q[30:0]));
                out_next.result   = out_next.overflow ? fpa_pkg::RAW_MIN
                                                      : (32'd0 - q[31:0]);
            end
            else
            begin
                out_next.overflow = |q[QW-1:31];
                out_next.result   = out_next.overflow ? fpa_pkg::RAW_MAX : q[31:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else
            out_vld_reg <= vld_reg[LAST];
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    `FPA_ASSERT_IMP(a_one_cmp, done, $onehot({rsp.a_greater, rsp.a_less, rsp.a_equal}), "compare flags not one-hot")
    `FPA_ASSERT_IMP(a_dz_no_ovf, done, !(rsp.overflow && rsp.divide_by_zero), "overflow with divide by zero")
    `FPA_ASSERT_IMP(a_latency, start && !busy, ##(QW + 3) done, "word lost in pipeline")
    `FPA_ASSERT_IMP(a_dz_value, done && rsp.divide_by_zero, rsp.result == fpa_pkg::RAW_MAX || rsp.result == fpa_pkg::RAW_MIN || rsp.result == 32'sd0, "bad divide by zero value")

endmodule

/* bench/fixed_point_alu_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for the fixed-point ALU: predicts each accepted word and checks done words.
// Depends on fpa_pkg.
module fixed_point_alu_checker #(
    parameter int FRAC_BITS = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          busy,
    input  fpa_pkg::in_t  req,
    input  logic          done,
    input  fpa_pkg::out_t rsp,
    output int            errors,
    output int            pending
);
    import fpa_pkg::*;

    out_t expected_q[$];

    function automatic longint clamp32(longint v, inout bit ovf);
        if (v > longint'(32'sh7FFF_FFFF))
        begin
            ovf = 1'b1;
            return longint'(32'sh7FFF_FFFF);
        end
        if (v < -longint'(64'sh8000_0000))
        begin
            ovf = 1'b1;
            return -longint'(64'sh8000_0000);
        end
        return v;
    endfunction

    function automatic logic [63:0] magnitude(longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic out_t alu_predict(in_t w);
        longint      a;
        longint      b;
        longint      p;
        longint      r;
        logic [63:0] m;
        logic [63:0] n;
        logic [63:0] d;
        logic [63:0] q;
        bit          ovf;
        bit          dz;
        out_t        o;
        a = longint'(w.operand_a);
        b = longint'(w.operand_b);
        ovf = 1'b0;
        dz = 1'b0;
        r = 0;
        case (w.cmd)
            CMD_ADD: r = clamp32(a + b, ovf);
            CMD_SUB: r = clamp32(a - b, ovf);
            CMD_MUL:
            begin
                p = a * b;
                m = magnitude(p);
                // round half away from zero on the magnitude
                if (FRAC_BITS > 0)
                    m = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
                r = clamp32((p < 0) ? -longint'(m) : longint'(m), ovf);
            end
            CMD_DIV:
            begin
                if (b == 0)
                begin
                    dz = 1'b1;
                    r = (a > 0) ? longint'(32'sh7FFF_FFFF)
                        : ((a < 0) ? -longint'(64'sh8000_0000) : 0);
                end
                else
                begin
                    n = magnitude(a) << FRAC_BITS;
                    d = magnitude(b);
                    q = (2 * n + d) / (2 * d);
                    r = clamp32(((a < 0) != (b < 0)) ? -longint'(q) : longint'(q), ovf);
                end
            end
            CMD_MIN: r = (a < b) ? a : b;
            CMD_MAX: r = (a > b) ? a : b;
            CMD_INC: r = clamp32(a + 1, ovf);
            CMD_DEC: r = clamp32(a - 1, ovf);
            CMD_TO_INT: r = longint'(w.operand_a >>> FRAC_BITS);
            CMD_FROM_INT: r = clamp32(a * (longint'(1) << FRAC_BITS), ovf);
            default: r = 0;
        endcase
        o.result = r[31:0];
        o.a_greater = a > b;
        o.a_less = a < b;
        o.a_equal = a == b;
        o.overflow = ovf;
        o.divide_by_zero = dz;
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_t exp_w;
        if (!rst_n)
        begin
            errors <= 0;
            pending <= 0;
            expected_q.delete();
        end
        else
        begin
            if (done)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("done word with nothing expected: result %0d", rsp.result);
                    errors <= errors + 1;
                end
                else
                begin
                    exp_w = expected_q.pop_front();
                    if (rsp != exp_w)
                    begin
                        errors <= errors + 1;
                        if (rsp.result !== exp_w.result)
                            $error("result: expected %0d, got %0d", exp_w.result, rsp.result);
                        if (rsp.a_greater !== exp_w.a_greater)
                            $error("a_greater: expected %0b, got %0b",
                                   exp_w.a_greater, rsp.a_greater);
                        if (rsp.a_less !== exp_w.a_less)
                            $error("a_less: expected %0b, got %0b", exp_w.a_less, rsp.a_less);
                        if (rsp.a_equal !== exp_w.a_equal)
                            $error("a_equal: expected %0b, got %0b", exp_w.a_equal, rsp.a_equal);
                        if (rsp.overflow !== exp_w.overflow)
                            $error("overflow: expected %0b, got %0b",
                                   exp_w.overflow, rsp.overflow);
                        if (rsp.divide_by_zero !== exp_w.divide_by_zero)
                            $error("divide_by_zero: expected %0b, got %0b",
                                   exp_w.divide_by_zero, rsp.divide_by_zero);
                    end
                end
            end
            if (start && !busy)
                expected_q.push_back(alu_predict(req));
            pending <= expected_q.size();
        end
    end

endmodule

/* bench/tb_fixed_point_alu.sv */
`timescale 1ns / 100ps
// Top of the fixed-point ALU bench: clock, reset, stimulus and verdict.
// Depends on fpa_pkg, fixed_point_alu and fixed_point_alu_checker.
module tb_fixed_point_alu;
    import fpa_pkg::*;

    localparam int FRAC_BITS = 8;
    localparam int RANDOM_WORDS = 500;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = FRAC_BITS + 60;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  start = 1'b0;
    logic  busy;
    logic  done;
    in_t   req = '0;
    out_t  rsp;
    int    errors;
    int    pending;
    int    stall_cycles = 0;

    always #10 clk = ~clk;

    fixed_point_alu #(.FRAC_BITS(FRAC_BITS)) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    fixed_point_alu_checker #(.FRAC_BITS(FRAC_BITS)) i_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .req     (req),
        .done    (done),
        .rsp     (rsp),
        .errors  (errors),
        .pending (pending)
    );

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("FAIL fixed_point_alu");
                $finish;
            end
        end
    end

    // hold the word until accepted; start stays high for the caller
    task automatic send_word(logic [3:0] op, logic [31:0] a, logic [31:0] b);
        start <= 1'b1;
        req <= '{cmd: op, operand_a: a, operand_b: b};
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic idle_burst();
        start <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 2000) - 1000;
            1: return (32'd1 << $urandom_range(0, 31)) + $urandom_range(0, 2) - 1;
            2: return RAW_MAX - $urandom_range(0, 3);
            3: return RAW_MIN + $urandom_range(0, 3);
            4: return 32'sd256 * ($urandom_range(0, 200) - 100);
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        logic [3:0] op;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(CMD_ADD, RAW_MAX, 32'd1);
        send_word(CMD_ADD, RAW_MIN, RAW_MIN);
        send_word(CMD_SUB, RAW_MIN, 32'd1);
        send_word(CMD_SUB, RAW_MAX, -32'sd1);
        send_word(CMD_MUL, 32'd1, 32'd128);
        send_word(CMD_MUL, -32'sd1, 32'd128);
        send_word(CMD_MUL, RAW_MAX, RAW_MAX);
        send_word(CMD_MUL, RAW_MIN, RAW_MAX);
        send_word(CMD_DIV, 32'd100, 32'd0);
        send_word(CMD_DIV, -32'sd100, 32'd0);
        send_word(CMD_DIV, 32'd0, 32'd0);
        send_word(CMD_DIV, RAW_MAX, 32'd1);
        send_word(CMD_DIV, 32'd1, 32'd512);
        send_word(CMD_DIV, RAW_MIN, -32'sd1);
        send_word(CMD_MIN, RAW_MIN, RAW_MAX);
        send_word(CMD_MAX, RAW_MIN, RAW_MAX);
        send_word(CMD_INC, RAW_MAX, 32'd5);
        send_word(CMD_DEC, RAW_MIN, RAW_MIN);
        send_word(CMD_TO_INT, -32'sd1, 32'd0);
        send_word(CMD_TO_INT, RAW_MAX, 32'd0);
        send_word(CMD_FROM_INT, 32'h0080_0000, 32'd0);
        send_word(CMD_FROM_INT, 32'hFF7F_FFFF, 32'd0);
        send_word(4'd10, 32'd7, 32'd7);
        send_word(4'd15, 32'd3, 32'd9);

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            // mostly valid codes, a few unused ones
            op = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(10, 15))
                : 4'($urandom_range(0, 9));
            if (i < RANDOM_WORDS - 100 && $urandom_range(0, 4) == 0)
                idle_burst();
            if ($urandom_range(0, 7) == 0)
                send_word(op, $urandom, $urandom);
            else
                send_word(op, pick_operand(), pick_operand());
        end
        start <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("PASS fixed_point_alu");
        else
            $display("FAIL fixed_point_alu");
        $finish;
    end

endmodule
